>>> hw/rtl/bmic_pkg.sv
// ----------------------------------------------------------------------------
// bmic_pkg: shared types and constants
// Op codes, targets, csr indexes and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package bmic_pkg;

   typedef enum logic [2:0] {
      OP_CPU_RD = 3'd0,
      OP_CPU_WR = 3'd1,
      OP_PPU_RD = 3'd2,
      OP_PPU_WR = 3'd3,
      OP_TICK   = 3'd4,
      OP_INIT   = 3'd5,
      OP_RSV6   = 3'd6,
      OP_RSV7   = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      TGT_NONE = 3'd0,
      TGT_PRG  = 3'd1,
      TGT_CHR  = 3'd2,
      TGT_NT   = 3'd3,
      TGT_REG  = 3'd4
   } target_type;

   localparam logic [1:0] CSR_PRG_COUNT = 2'd0;
   localparam logic [1:0] CSR_CHR_COUNT = 2'd1;
   localparam logic [1:0] CSR_CHR_WR    = 2'd2;
   localparam logic [1:0] CSR_MIRROR_H  = 2'd3;

   localparam logic [14:0] IRQ_TOP = 15'h7FFF;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture the request word
      logic clear;    // sweep step of RAM clear
      logic execute;  // perform the access, compute result
      logic emit;     // present result strobe
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_done;
      logic init_req;
      logic mod_done;
   } status_type;

endpackage

>>> hw/rtl/banked_mapper_with_irq_counter_unit.sv
// ----------------------------------------------------------------------------
// banked_mapper_with_irq_counter_unit: bank-switching mapper top level
// After reset the block clears its 128-byte sound RAM (busy high meanwhile)
// and does the same after every init word. Each word is taken when start is
// high and busy low; its result is strobed on rsp_valid for one cycle, while
// the block is in its emit state, and the next word can be taken only once
// the block is back in idle: bit-serial bank modulo (setup plus 9 steps),
// then execute, emit and a return to idle, where start is sampled.
// The receiver cannot stall: results must be taken when strobed.
// ----------------------------------------------------------------------------
module banked_mapper_with_irq_counter_unit
   import bmic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_bus_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_tick_cycles,
   output logic        rsp_valid,
   output logic [2:0]  rsp_target,
   output logic [18:0] rsp_mem_offset,
   output logic        rsp_mem_write,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_prg_ram_write_ok,
   output logic        rsp_irq_line,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [6:0] prg_cnt_ff;
   logic [8:0] chr_cnt_ff;
   logic       chr_wr_ff, mirror_ff;

   assign pready = 1'b1;
   wire csr_we = psel && penable && pwrite;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_cnt_ff <= 7'd64;
         chr_cnt_ff <= 9'd256;
         chr_wr_ff  <= 1'b0;
         mirror_ff  <= 1'b0;
      end else if (csr_we && paddr[1:0] == 2'b00) begin
         unique case (paddr[3:2])
            CSR_PRG_COUNT: prg_cnt_ff <= pwdata[6:0];
            CSR_CHR_COUNT: chr_cnt_ff <= pwdata[8:0];
            CSR_CHR_WR:    chr_wr_ff  <= pwdata[0];
            CSR_MIRROR_H:  mirror_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr[3:2])
         CSR_PRG_COUNT: prdata = {25'd0, prg_cnt_ff};
         CSR_CHR_COUNT: prdata = {23'd0, chr_cnt_ff};
         CSR_CHR_WR:    prdata = {31'd0, chr_wr_ff};
         CSR_MIRROR_H:  prdata = {31'd0, mirror_ff};
         default: ;
      endcase
   end

   cmd_type    cmd;
   status_type status;

   bmic_ctrl u_ctrl (
      .clock, .reset, .start, .status, .cmd, .busy
   );

   bmic_dp u_dp (
      .clock, .reset, .cmd, .status,
      .req_op, .req_bus_address, .req_write_data, .req_tick_cycles,
      .prg_bank_count(prg_cnt_ff), .chr_bank_count(chr_cnt_ff),
      .chr_is_writable(chr_wr_ff), .mirror_horizontal(mirror_ff),
      .rsp_valid, .rsp_target, .rsp_mem_offset, .rsp_mem_write,
      .rsp_read_data, .rsp_prg_ram_write_ok, .rsp_irq_line
   );

endmodule

>>> hw/rtl/bmic_ctrl.sv
// ----------------------------------------------------------------------------
// bmic_ctrl: sequencer
// Runs the RAM clear sweep, then load, modulo wait, execute and emit per word.
// ----------------------------------------------------------------------------
module bmic_ctrl
   import bmic_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_MOD   = 5'b00100,
      ST_EXEC  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE:  if (start) state_in = ST_MOD;
         ST_MOD:   if (status.mod_done) state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_EMIT;
         ST_EMIT:  state_in = status.init_req ? ST_CLEAR : ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign cmd.load    = (state_ff == ST_IDLE) && start;
   assign cmd.clear   = (state_ff == ST_CLEAR);
   assign cmd.execute = (state_ff == ST_EXEC);
   assign cmd.emit    = (state_ff == ST_EMIT);

   // a word is taken only when idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_MOD) else $error("load left wrong state");
   a_emit_after_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> $past(cmd.execute)) else $error("emit without execute");
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");

endmodule

>>> hw/rtl/bmic_dp.sv
// ----------------------------------------------------------------------------
// bmic_dp: datapath
// Bank/control registers, IRQ counter, sound RAM, bank modulo unit, result.
// ----------------------------------------------------------------------------
module bmic_dp
   import bmic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_bus_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_tick_cycles,
   input  logic [6:0]  prg_bank_count,
   input  logic [8:0]  chr_bank_count,
   input  logic        chr_is_writable,
   input  logic        mirror_horizontal,
   output logic        rsp_valid,
   output logic [2:0]  rsp_target,
   output logic [18:0] rsp_mem_offset,
   output logic        rsp_mem_write,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_prg_ram_write_ok,
   output logic        rsp_irq_line
);

   // captured word
   op_type      op_ff;
   logic [15:0] addr_ff;
   logic [7:0]  wdata_ff, cyc_ff;

   // state
   logic [7:0]  chr_banks_ff [12];
   logic [5:0]  prg_banks_ff [3];
   logic [7:0]  e800_ff, f800_ff;
   logic [14:0] irq_count_ff;
   logic        irq_en_ff, irq_pend_ff;
   logic [6:0]  ptr_ff;
   logic        auto_inc_ff, snd_dis_ff;
   logic [7:0]  sram [128];
   logic [6:0]  clr_idx_ff;

   // modulo unit: restoring remainder, one quotient bit per cycle
   logic [8:0]  rem_ff;
   logic [8:0]  div_ff;
   logic [3:0]  mcnt_ff;
   logic [8:0]  num_ff;

   // PPU address decode
   logic [13:0] p;
   logic [7:0]  ppu_bank;
   logic        internal;
   always_comb begin
      p = addr_ff[13:0];
      if (p >= 14'h3000 && p < 14'h3F00) p = p - 14'h1000;
      if (p < 14'h2000) ppu_bank = chr_banks_ff[{1'b0, p[12:10]}];
      else              ppu_bank = chr_banks_ff[4'd8 + {2'b00, p[11:10]}];
      if (ppu_bank < 8'hE0)       internal = 1'b0;
      else if (p < 14'h1000)      internal = ~e800_ff[6];
      else if (p < 14'h2000)      internal = ~e800_ff[7];
      else                        internal = 1'b1;
   end

   // PRG bank select
   logic [6:0] prg_n;
   logic [1:0] prg_sel;
   logic [6:0] prg_bank;
   always_comb begin
      prg_n   = (prg_bank_count > 7'd64) ? 7'd64 : prg_bank_count;
      prg_sel = addr_ff[14:13];
      prg_bank = (prg_sel == 2'd3) ? prg_n - 7'd1 : {1'b0, prg_banks_ff[prg_sel]};
   end

   wire is_ppu = (op_ff == OP_PPU_RD) || (op_ff == OP_PPU_WR);

   // divider: loaded on the cycle after capture
   logic mod_busy_ff;
   logic [9:0] trial;
   assign trial = {rem_ff, num_ff[8]} - {1'b0, div_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_busy_ff <= 1'b0;
         mcnt_ff     <= '0;
      end else if (cmd.load) begin
         mod_busy_ff <= 1'b1;
         mcnt_ff     <= 4'd0;
      end else if (mod_busy_ff) begin
         if (mcnt_ff == 4'd0) begin
            rem_ff  <= '0;
            num_ff  <= is_ppu ? {1'b0, ppu_bank} : {2'b00, prg_bank};
            div_ff  <= is_ppu ? chr_bank_count : {2'b00, prg_n};
            mcnt_ff <= 4'd1;
         end else begin
            rem_ff  <= trial[9] ? {rem_ff[7:0], num_ff[8]} : trial[8:0];
            num_ff  <= {num_ff[7:0], 1'b0};
            mcnt_ff <= mcnt_ff + 4'd1;
            if (mcnt_ff == 4'd9) mod_busy_ff <= 1'b0;
         end
      end
   end
   assign status.mod_done = mod_busy_ff && (mcnt_ff == 4'd9);

   // capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_op);
         addr_ff  <= req_bus_address;
         wdata_ff <= req_write_data;
         cyc_ff   <= req_tick_cycles;
      end
   end

   // PRG-RAM write permission
   logic ok;
   always_comb begin
      ok = 1'b0;
      if (addr_ff[15:13] == 3'b011 && f800_ff[7:4] == 4'h4)
         ok = ~f800_ff[addr_ff[12:11]];
   end

   logic [7:0]  sram_q;
   logic [14:0] head;
   assign head = IRQ_TOP - irq_count_ff;
   wire in48 = addr_ff[15:11] == 5'b01001;
   wire in50 = addr_ff[15:11] == 5'b01010;
   wire in58 = addr_ff[15:11] == 5'b01011;
   wire hi   = addr_ff[15];
   logic [3:0] slot;
   assign slot = addr_ff[14:11];
   wire sram_wr = cmd.execute && op_ff == OP_CPU_WR && in48;

   // sound RAM: clear sweep or write port, registered read
   always_ff @(posedge clock) begin
      if (cmd.clear) sram[clr_idx_ff] <= 8'h00;
      else if (sram_wr) sram[ptr_ff] <= wdata_ff;
      sram_q <= sram[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) clr_idx_ff <= '0;
      else if (cmd.clear) clr_idx_ff <= clr_idx_ff + 7'd1;
   end
   assign status.clear_done = cmd.clear && (clr_idx_ff == 7'h7F);

   logic init_ff;
   assign status.init_req = init_ff;

   // state update and result formation
   always_ff @(posedge clock) begin
      if (reset || (cmd.execute && op_ff == OP_INIT)) begin
         for (int i = 0; i < 8; i++) chr_banks_ff[i] <= 8'(i);
         chr_banks_ff[8]  <= 8'hFE;
         chr_banks_ff[9]  <= (mirror_horizontal && !reset) ? 8'hFE : 8'hFF;
         chr_banks_ff[10] <= (mirror_horizontal && !reset) ? 8'hFF : 8'hFE;
         chr_banks_ff[11] <= 8'hFF;
         prg_banks_ff[0] <= 6'd0; prg_banks_ff[1] <= 6'd1; prg_banks_ff[2] <= 6'd2;
         e800_ff <= '0; f800_ff <= '0; irq_count_ff <= '0;
         irq_en_ff <= 1'b0; irq_pend_ff <= 1'b0; ptr_ff <= '0;
         auto_inc_ff <= 1'b0; snd_dis_ff <= 1'b0;
      end else if (cmd.execute) begin
         unique case (op_ff)
            OP_CPU_RD: if (in48 && auto_inc_ff) ptr_ff <= ptr_ff + 7'd1;
            OP_CPU_WR: begin
               if (in48) begin
                  if (auto_inc_ff) ptr_ff <= ptr_ff + 7'd1;
               end else if (in50) begin
                  irq_count_ff[7:0] <= wdata_ff; irq_pend_ff <= 1'b0;
               end else if (in58) begin
                  irq_count_ff[14:8] <= wdata_ff[6:0];
                  irq_en_ff <= wdata_ff[7]; irq_pend_ff <= 1'b0;
               end else if (hi) begin
                  if (slot < 4'd12) chr_banks_ff[slot] <= wdata_ff;
                  else if (slot == 4'd12) begin
                     prg_banks_ff[0] <= wdata_ff[5:0]; snd_dis_ff <= wdata_ff[6];
                  end else if (slot == 4'd13) begin
                     prg_banks_ff[1] <= wdata_ff[5:0]; e800_ff <= wdata_ff;
                  end else if (slot == 4'd14) prg_banks_ff[2] <= wdata_ff[5:0];
                  else begin
                     f800_ff <= wdata_ff; ptr_ff <= wdata_ff[6:0];
                     auto_inc_ff <= wdata_ff[7];
                  end
               end
            end
            OP_TICK: begin
               if (cyc_ff != 8'd0 && irq_en_ff && !irq_pend_ff && irq_count_ff < IRQ_TOP) begin
                  if ({7'd0, cyc_ff} >= head) begin
                     irq_count_ff <= IRQ_TOP; irq_pend_ff <= 1'b1;
                  end else irq_count_ff <= irq_count_ff + {7'd0, cyc_ff};
               end
            end
            default: ;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
         init_ff   <= 1'b0;
      end else begin
         rsp_valid <= cmd.execute;
         if (cmd.execute) init_ff <= (op_ff == OP_INIT);
      end
      if (cmd.execute) begin
         rsp_target           <= TGT_NONE;
         rsp_mem_offset       <= '0;
         rsp_mem_write        <= 1'b0;
         rsp_read_data        <= 8'hFF;
         rsp_prg_ram_write_ok <= 1'b0;
         unique case (op_ff)
            OP_CPU_RD: begin
               rsp_prg_ram_write_ok <= ok;
               if (in48) begin
                  rsp_target <= TGT_REG; rsp_read_data <= sram_q;
               end else if (in50) begin
                  rsp_target <= TGT_REG; rsp_read_data <= irq_count_ff[7:0];
               end else if (in58) begin
                  rsp_target <= TGT_REG;
                  rsp_read_data <= {irq_en_ff, irq_count_ff[14:8]};
               end else if (hi && prg_n != 7'd0) begin
                  rsp_target <= TGT_PRG; rsp_read_data <= 8'h00;
                  rsp_mem_offset <= {rem_ff[5:0], addr_ff[12:0]};
               end
            end
            OP_CPU_WR: rsp_prg_ram_write_ok <= ok;
            OP_PPU_RD, OP_PPU_WR: begin
               if (internal) begin
                  rsp_target <= TGT_NT; rsp_read_data <= 8'h00;
                  rsp_mem_offset <= {8'd0, ppu_bank[0], p[9:0]};
                  rsp_mem_write <= (op_ff == OP_PPU_WR);
               end else if (chr_bank_count != 9'd0) begin
                  rsp_target <= TGT_CHR; rsp_read_data <= 8'h00;
                  rsp_mem_offset <= {1'b0, rem_ff[7:0], p[9:0]};
                  rsp_mem_write <= (op_ff == OP_PPU_WR) && chr_is_writable;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_irq_line = irq_pend_ff;

   a_pend_sat: assert property (@(posedge clock) disable iff (reset)
      $rose(irq_pend_ff) |-> irq_count_ff == IRQ_TOP) else $error("pending w/o top");
   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double strobe");
   a_exec_mod: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> !mod_busy_ff) else $error("execute before modulo");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: bench for the banked mapper with IRQ counter
// Drives CPU/PPU accesses, ticks and init words under random burst gaps,
// predicts every result word with a behavioral mapper model and checks each
// strobed result against the oldest prediction. Sweeps the csr settings.
// ----------------------------------------------------------------------------
import bmic_pkg::*;

typedef struct packed {
   logic [2:0]  target;
   logic [18:0] offset;
   logic        wr;
   logic [7:0]  rdata;
   logic        ram_ok;
   logic        irq;
} map_result_t;

class mapper_scoreboard;
   // csr copy
   logic [6:0]  prg_count;
   logic [8:0]  chr_count;
   logic        chr_wr_en;
   logic        mirror_h;
   // mapper state
   logic [7:0]  chr_bank [12];
   logic [5:0]  prg_bank [3];
   logic [7:0]  e800, f800;
   logic [14:0] irq_cnt;
   logic        irq_en, irq_pend;
   logic [6:0]  ptr;
   logic        auto_inc, snd_off;
   logic [7:0]  snd_ram [128];
   map_result_t pending_q [$];
   int          errors;

   function new();
      errors    = 0;
      prg_count = 7'd64;
      chr_count = 9'd256;
      chr_wr_en = 1'b0;
      mirror_h  = 1'b0;
      load_defaults();
   endfunction

   function void load_defaults();
      for (int i = 0; i < 8; i++) chr_bank[i] = i[7:0];
      chr_bank[8]  = 8'hFE;
      chr_bank[11] = 8'hFF;
      chr_bank[9]  = mirror_h ? 8'hFE : 8'hFF;
      chr_bank[10] = mirror_h ? 8'hFF : 8'hFE;
      for (int i = 0; i < 3; i++) prg_bank[i] = i[5:0];
      e800 = 0; f800 = 0; irq_cnt = 0; irq_en = 0; irq_pend = 0;
      ptr = 0; auto_inc = 0; snd_off = 0;
      for (int i = 0; i < 128; i++) snd_ram[i] = 0;
   endfunction

   function void set_csr(logic [1:0] idx, logic [31:0] v);
      case (idx)
         CSR_PRG_COUNT: prg_count = v[6:0];
         CSR_CHR_COUNT: chr_count = v[8:0];
         CSR_CHR_WR:    chr_wr_en = v[0];
         CSR_MIRROR_H:  mirror_h  = v[0];
         default: ;
      endcase
   endfunction

   function logic ram_write_ok(logic [15:0] a);
      int win;
      if (a < 16'h6000 || a > 16'h7FFF) return 1'b0;
      if (f800[7:4] != 4'h4) return 1'b0;
      win = (a - 16'h6000) >> 11;
      return !f800[win];
   endfunction

   // predict the result word for one accepted request word
   function void note_request(op_type op, logic [15:0] a, logic [7:0] d, logic [7:0] cyc);
      map_result_t r;
      int n, sel, bank, slot;
      int p;
      logic internal;
      r = '0;
      r.target = TGT_NONE;
      r.rdata  = 8'hFF;
      case (op)
         OP_CPU_RD: begin
            if (a >= 16'h4800 && a <= 16'h4FFF) begin
               r.target = TGT_REG; r.rdata = snd_ram[ptr];
               if (auto_inc) ptr = ptr + 7'd1;
            end else if (a >= 16'h5000 && a <= 16'h57FF) begin
               r.target = TGT_REG; r.rdata = irq_cnt[7:0];
            end else if (a >= 16'h5800 && a <= 16'h5FFF) begin
               r.target = TGT_REG; r.rdata = {irq_en, irq_cnt[14:8]};
            end else if (a >= 16'h8000) begin
               n = prg_count > 64 ? 64 : prg_count;
               if (n != 0) begin
                  sel  = a[14:13];
                  bank = sel == 3 ? n - 1 : prg_bank[sel];
                  r.target = TGT_PRG; r.rdata = 0;
                  r.offset = 19'((bank % n) * 8192 + a[12:0]);
               end
            end
            r.ram_ok = ram_write_ok(a);
         end
         OP_CPU_WR: begin
            if (a >= 16'h4800 && a <= 16'h4FFF) begin
               snd_ram[ptr] = d;
               if (auto_inc) ptr = ptr + 7'd1;
            end else if (a >= 16'h5000 && a <= 16'h57FF) begin
               irq_cnt[7:0] = d; irq_pend = 0;
            end else if (a >= 16'h5800 && a <= 16'h5FFF) begin
               irq_cnt[14:8] = d[6:0]; irq_en = d[7]; irq_pend = 0;
            end else if (a >= 16'h8000) begin
               slot = (a - 16'h8000) >> 11;
               if (slot < 12) chr_bank[slot] = d;
               else if (slot == 12) begin
                  prg_bank[0] = d[5:0]; snd_off = d[6];
               end else if (slot == 13) begin
                  prg_bank[1] = d[5:0]; e800 = d;
               end else if (slot == 14) prg_bank[2] = d[5:0];
               else begin
                  f800 = d; ptr = d[6:0]; auto_inc = d[7];
               end
            end
            r.ram_ok = ram_write_ok(a);
         end
         OP_PPU_RD, OP_PPU_WR: begin
            p = a[13:0];
            if (p >= 'h3000 && p < 'h3F00) p -= 'h1000;
            if (p < 'h2000) bank = chr_bank[(p >> 10) & 7];
            else bank = chr_bank[8 + ((p >> 10) & 3)];
            if (bank < 'hE0) internal = 0;
            else if (p < 'h1000) internal = !e800[6];
            else if (p < 'h2000) internal = !e800[7];
            else internal = 1;
            if (internal) begin
               r.target = TGT_NT; r.rdata = 0;
               r.offset = 19'(((bank & 1) ? 'h400 : 0) + (p & 'h3FF));
               r.wr = op == OP_PPU_WR;
            end else if (chr_count != 0) begin
               r.target = TGT_CHR; r.rdata = 0;
               r.offset = 19'((bank % chr_count) * 1024 + (p & 'h3FF));
               r.wr = op == OP_PPU_WR && chr_wr_en;
            end
         end
         OP_TICK: begin
            if (cyc != 0 && irq_en && !irq_pend && irq_cnt < IRQ_TOP) begin
               if (cyc >= IRQ_TOP - irq_cnt) begin
                  irq_cnt = IRQ_TOP; irq_pend = 1;
               end else irq_cnt = irq_cnt + cyc;
            end
         end
         OP_INIT: load_defaults();
         default: ;
      endcase
      r.irq = irq_pend;
      pending_q.push_back(r);
   endfunction

   function void check_result(map_result_t got);
      map_result_t exp_r;
      if (pending_q.size() == 0) begin
         $error("result word with nothing expected");
         errors++;
         return;
      end
      exp_r = pending_q.pop_front();
      if (got.target !== exp_r.target) begin
         $error("target exp %0d got %0d", exp_r.target, got.target); errors++;
      end
      if (got.offset !== exp_r.offset) begin
         $error("mem_offset exp %h got %h", exp_r.offset, got.offset); errors++;
      end
      if (got.wr !== exp_r.wr) begin
         $error("mem_write exp %0d got %0d", exp_r.wr, got.wr); errors++;
      end
      if (got.rdata !== exp_r.rdata) begin
         $error("read_data exp %h got %h", exp_r.rdata, got.rdata); errors++;
      end
      if (got.ram_ok !== exp_r.ram_ok) begin
         $error("prg_ram_write_ok exp %0d got %0d", exp_r.ram_ok, got.ram_ok); errors++;
      end
      if (got.irq !== exp_r.irq) begin
         $error("irq_line exp %0d got %0d", exp_r.irq, got.irq); errors++;
      end
   endfunction
endclass

module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [2:0]  req_op = 0;
   logic [15:0] req_bus_address = 0;
   logic [7:0]  req_write_data = 0;
   logic [7:0]  req_tick_cycles = 0;
   logic        rsp_valid;
   logic [2:0]  rsp_target;
   logic [18:0] rsp_mem_offset;
   logic        rsp_mem_write;
   logic [7:0]  rsp_read_data;
   logic        rsp_prg_ram_write_ok;
   logic        rsp_irq_line;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [3:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   mapper_scoreboard sb;
   int unsigned cycle_count = 0;
   localparam int unsigned CYCLE_LIMIT = 400000;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   banked_mapper_with_irq_counter_unit DUT (.*);

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result({rsp_target, rsp_mem_offset, rsp_mem_write, rsp_read_data,
                          rsp_prg_ram_write_ok, rsp_irq_line});
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] v);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      sb.set_csr(idx, v);
   endtask

   // one request word; holds start until the block takes it
   task automatic send_word(op_type op, logic [15:0] a, logic [7:0] d, logic [7:0] cyc);
      start <= 1; req_op <= op; req_bus_address <= a;
      req_write_data <= d; req_tick_cycles <= cyc;
      do @(posedge clock); while (busy);
      sb.note_request(op, a, d, cyc);
   endtask

   // random gap between bursts
   int burst_left = 0;
   task automatic pace();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            start <= 0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic drain();
      @(posedge clock);
      start <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // random mostly-meaningful access
   task automatic random_word();
      int     k;
      logic [15:0] a;
      op_type op;
      k  = $urandom_range(0, 99);
      a  = 16'($urandom);
      if (k < 25) begin
         op = OP_CPU_RD;
         case ($urandom_range(0, 3))
            0: a = 16'($urandom_range(16'h4800, 16'h5FFF));
            1: a = 16'($urandom_range(16'h6000, 16'h7FFF));
            default: ;
         endcase
      end else if (k < 50) begin
         op = OP_CPU_WR;
         case ($urandom_range(0, 4))
            0: a = 16'($urandom_range(16'h4800, 16'h5FFF));
            1: a = 16'($urandom_range(16'hE000, 16'hFFFF));
            2: a = 16'($urandom_range(16'h8000, 16'hDFFF));
            default: ;
         endcase
      end else if (k < 75) op = $urandom_range(0, 1) ? OP_PPU_RD : OP_PPU_WR;
      else if (k < 92) op = OP_TICK;
      else if (k < 94) op = OP_INIT;
      else if (k < 97) op = $urandom_range(0, 1) ? OP_RSV6 : OP_RSV7;
      else op = op_type'($urandom_range(0, 7));
      send_word(op, a, 8'($urandom),
                ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 0;

      // directed: extremes, every op, special cases
      send_word(OP_CPU_RD, 16'h8000, 0, 0);
      send_word(OP_CPU_RD, 16'hFFFF, 0, 0);
      send_word(OP_CPU_RD, 16'h0000, 0, 0);
      send_word(OP_CPU_WR, 16'hF800, 8'hC0, 0);      // ptr 0x40, auto increment
      send_word(OP_CPU_WR, 16'h4800, 8'hA5, 0);
      send_word(OP_CPU_RD, 16'h4FFF, 0, 0);
      send_word(OP_CPU_WR, 16'hF800, 8'h45, 0);      // PRG-RAM write protect
      send_word(OP_CPU_WR, 16'h6800, 8'hFF, 0);
      send_word(OP_CPU_RD, 16'h7FFF, 0, 0);
      send_word(OP_CPU_WR, 16'h5000, 8'hF0, 0);
      send_word(OP_CPU_WR, 16'h5800, 8'hFF, 0);      // enable, near top
      send_word(OP_TICK, 0, 0, 8'h00);                // zero-cycle tick
      send_word(OP_TICK, 0, 0, 8'hFF);                // saturates
      send_word(OP_CPU_RD, 16'h5000, 0, 0);
      send_word(OP_CPU_RD, 16'h5800, 0, 0);
      send_word(OP_PPU_RD, 16'h3F00, 0, 0);           // palette range
      send_word(OP_PPU_WR, 16'hFFFF, 8'hFF, 0);
      send_word(OP_PPU_RD, 16'h2C00, 0, 0);
      send_word(OP_CPU_WR, 16'hE800, 8'hC0, 0);
      send_word(OP_CPU_WR, 16'h8000, 8'hE0, 0);
      send_word(OP_PPU_WR, 16'h0000, 8'h00, 0);
      send_word(OP_RSV6, 16'hFFFF, 8'hFF, 8'hFF);
      send_word(OP_RSV7, 0, 0, 0);
      send_word(OP_INIT, 0, 0, 0);
      drain();

      // random phases across csr settings, extremes first
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin csr_write(CSR_PRG_COUNT, 0);   csr_write(CSR_CHR_COUNT, 0); end
            1: begin csr_write(CSR_PRG_COUNT, 127); csr_write(CSR_CHR_COUNT, 511); end
            2: begin csr_write(CSR_PRG_COUNT, 1);   csr_write(CSR_CHR_COUNT, 1); end
            default: begin
               csr_write(CSR_PRG_COUNT, $urandom_range(0, 127));
               csr_write(CSR_CHR_COUNT, $urandom_range(0, 511));
            end
         endcase
         csr_write(CSR_CHR_WR, 32'(ph & 1));
         csr_write(CSR_MIRROR_H, 32'((ph >> 1) & 1));
         send_word(OP_INIT, 0, 0, 0);
         // ramp the counter so ticks reach the top
         send_word(OP_CPU_WR, 16'h5800, 8'hFF, 0);
         for (int i = 0; i < 60; i++) begin
            pace();
            random_word();
         end
         drain();
      end

      if (sb.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

>>> filelist.f
hw/rtl/bmic_pkg.sv
hw/rtl/bmic_ctrl.sv
hw/rtl/bmic_dp.sv
hw/rtl/banked_mapper_with_irq_counter_unit.sv
bench/tb.sv
